// ===== rtl/lcs_pkg.sv =====
// Shared constants and sequencer state type for the linear congruence solver.
package lcs_pkg;

	localparam int WIDTH = 32;
	localparam int NW    = WIDTH - 1;
	localparam int CW    = $clog2(WIDTH + 1);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_RED  = 12'b0000_0000_0010,
		ST_GCD  = 12'b0000_0000_0100,
		ST_MP   = 12'b0000_0000_1000,
		ST_OK   = 12'b0000_0001_0000,
		ST_AP   = 12'b0000_0010_0000,
		ST_R1   = 12'b0000_0100_0000,
		ST_INV  = 12'b0000_1000_0000,
		ST_MUL  = 12'b0001_0000_0000,
		ST_FIN  = 12'b0010_0000_0000,
		ST_FMUL = 12'b0100_0000_0000,
		ST_OUT  = 12'b1000_0000_0000
	} state_t;

endpackage

// ===== rtl/linear_congruence_solver.sv =====
// Linear congruence solver: iterative divider and modular multiplier under a sequencer.
// Timing is data dependent: each division runs start, 32 quotient bits and hand-off,
// repeated over the Euclid steps for the gcd and the inverse, and each modular
// multiply runs until its second factor has been shifted down to zero.
// Throughput: one item at a time; the next beat is taken once the result is parked.
// Reset: arst_n clears the sequencer and the output valid; no result is pending.
module linear_congruence_solver import lcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [NW-1:0]        coefficient,
	input  logic signed [WIDTH-1:0] right_side,
	input  logic [NW-1:0]        modulus,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 solvable,
	output logic [NW-1:0]        divisor,
	output logic [NW-1:0]        first_solution,
	output logic [NW-1:0]        stride
);

	state_t state_q;
	logic   wait_q;

	// operand and working registers
	logic [WIDTH-1:0] a_q, m_q, mag_q, br_q, x_q, y_q, mp_q, ap_q, bp_q;
	logic [WIDTH-1:0] r0_q, r1_q, t0_q, t1_q, x0_q;
	logic             neg_q, ok_q;

	// shared divider
	logic             div_act_q;
	logic [CW-1:0]    div_cnt_q;
	logic [WIDTH-1:0] div_rem_q, div_quo_q, div_d_q;
	logic             div_start;
	logic [WIDTH-1:0] div_n, div_d;
	logic [WIDTH:0]   div_sh;
	logic             div_fin;

	// shift-and-add modular multiplier
	logic             mul_act_q;
	logic [WIDTH-1:0] mul_acc_q, mul_x_q, mul_y_q, mul_n_q;
	logic             mul_start;
	logic [WIDTH-1:0] mul_x, mul_y, mul_n;
	logic [WIDTH:0]   mul_s1, mul_s2;
	logic [WIDTH-1:0] mul_acc_nx, mul_x_nx;

	logic [WIDTH-1:0] q_red;
	logic [WIDTH-1:0] t2;

	assign in_ready = (state_q == ST_IDLE);
	assign div_fin  = wait_q & ~div_act_q;
	assign div_sh   = {div_rem_q, div_quo_q[WIDTH-1]};

	// reduced quotient and next Bezout coefficient
	assign q_red = (div_quo_q >= mp_q) ? div_quo_q - mp_q : div_quo_q;
	assign t2    = (t0_q >= mul_acc_q) ? t0_q - mul_acc_q : t0_q + (mp_q - mul_acc_q);

	// two modular additions per multiplier step
	assign mul_s1     = {1'b0, mul_acc_q} + {1'b0, mul_x_q};
	assign mul_s2     = {1'b0, mul_x_q} + {1'b0, mul_x_q};
	assign mul_acc_nx = (mul_s1 >= {1'b0, mul_n_q}) ? WIDTH'(mul_s1 - {1'b0, mul_n_q})
	                                                : WIDTH'(mul_s1);
	assign mul_x_nx   = (mul_s2 >= {1'b0, mul_n_q}) ? WIDTH'(mul_s2 - {1'b0, mul_n_q})
	                                                : WIDTH'(mul_s2);

	// select operands for the shared units
	always_comb begin
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		mul_start = 1'b0;
		mul_x     = '0;
		mul_y     = '0;
		mul_n     = '0;
		case (state_q)
			ST_RED: begin
				div_start = ~wait_q;
				div_n     = mag_q;
				div_d     = m_q;
			end
			ST_GCD: begin
				div_start = ~wait_q & (y_q != '0);
				div_n     = x_q;
				div_d     = y_q;
			end
			ST_MP: begin
				div_start = ~wait_q;
				div_n     = m_q;
				div_d     = x_q;
			end
			ST_OK: begin
				div_start = ~wait_q;
				div_n     = br_q;
				div_d     = x_q;
			end
			ST_AP: begin
				div_start = ~wait_q;
				div_n     = a_q;
				div_d     = x_q;
			end
			ST_R1: begin
				div_start = ~wait_q;
				div_n     = ap_q;
				div_d     = mp_q;
			end
			ST_INV: begin
				div_start = ~wait_q & (r1_q != '0);
				div_n     = r0_q;
				div_d     = r1_q;
				mul_start = div_fin;
				mul_x     = q_red;
				mul_y     = t1_q;
				mul_n     = mp_q;
			end
			ST_FIN: begin
				mul_start = 1'b1;
				mul_x     = t0_q;
				mul_y     = bp_q;
				mul_n     = mp_q;
			end
			default: begin
			end
		endcase
	end

	// divider: one restoring quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_act_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_act_q <= 1'b1;
			div_cnt_q <= CW'(WIDTH);
		end else if (div_act_q) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			if (div_cnt_q == CW'(1)) div_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_rem_q <= '0;
			div_quo_q <= div_n;
			div_d_q   <= div_d;
		end else if (div_act_q) begin
			if (div_sh >= {1'b0, div_d_q}) begin
				div_rem_q <= WIDTH'(div_sh - {1'b0, div_d_q});
				div_quo_q <= {div_quo_q[WIDTH-2:0], 1'b1};
			end else begin
				div_rem_q <= div_sh[WIDTH-1:0];
				div_quo_q <= {div_quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	// multiplier: one bit of the second factor a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_act_q <= 1'b0;
		end else if (mul_start) begin
			mul_act_q <= 1'b1;
		end else if (mul_act_q && mul_y_q == '0) begin
			mul_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			mul_acc_q <= '0;
			mul_x_q   <= mul_x;
			mul_y_q   <= mul_y;
			mul_n_q   <= mul_n;
		end else if (mul_act_q && mul_y_q != '0) begin
			if (mul_y_q[0]) mul_acc_q <= mul_acc_nx;
			mul_x_q <= mul_x_nx;
			mul_y_q <= mul_y_q >> 1;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (div_start) wait_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= (modulus == '0) ? ST_OUT : ST_RED;
				end
				ST_RED: if (div_fin) begin
					wait_q  <= 1'b0;
					state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (div_fin) wait_q <= 1'b0;
					else if (!wait_q && y_q == '0) state_q <= ST_MP;
				end
				ST_MP: if (div_fin) begin
					wait_q  <= 1'b0;
					state_q <= ST_OK;
				end
				ST_OK: if (div_fin) begin
					wait_q  <= 1'b0;
					state_q <= (div_rem_q == '0) ? ST_AP : ST_OUT;
				end
				ST_AP: if (div_fin) begin
					wait_q  <= 1'b0;
					state_q <= ST_R1;
				end
				ST_R1: if (div_fin) begin
					wait_q  <= 1'b0;
					state_q <= ST_INV;
				end
				ST_INV: begin
					if (div_fin) state_q <= ST_MUL;
					else if (!wait_q && r1_q == '0) state_q <= ST_FIN;
				end
				ST_MUL: if (!mul_act_q) begin
					wait_q  <= 1'b0;
					state_q <= ST_INV;
				end
				ST_FIN: state_q <= ST_FMUL;
				ST_FMUL: if (!mul_act_q) state_q <= ST_OUT;
				ST_OUT: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				a_q   <= {1'b0, coefficient};
				m_q   <= {1'b0, modulus};
				neg_q <= right_side[WIDTH-1];
				mag_q <= right_side[WIDTH-1] ? WIDTH'(-right_side) : WIDTH'(right_side);
				x_q   <= '0;
				mp_q  <= '0;
				x0_q  <= '0;
				ok_q  <= 1'b0;
			end
			ST_RED: if (div_fin) begin
				br_q <= (neg_q && div_rem_q != '0) ? m_q - div_rem_q
				                                   : (neg_q ? '0 : div_rem_q);
				x_q  <= a_q;
				y_q  <= m_q;
			end
			ST_GCD: if (div_fin) begin
				x_q <= y_q;
				y_q <= div_rem_q;
			end
			ST_MP: if (div_fin) mp_q <= div_quo_q;
			ST_OK: if (div_fin) begin
				bp_q <= div_quo_q;
				ok_q <= (div_rem_q == '0);
			end
			ST_AP: if (div_fin) ap_q <= div_quo_q;
			ST_R1: if (div_fin) begin
				r0_q <= mp_q;
				r1_q <= div_rem_q;
				t0_q <= '0;
				t1_q <= (mp_q > WIDTH'(1)) ? WIDTH'(1) : '0;
			end
			ST_INV: if (div_fin) begin
				r0_q <= r1_q;
				r1_q <= div_rem_q;
			end
			ST_MUL: if (!mul_act_q) begin
				t0_q <= t1_q;
				t1_q <= t2;
			end
			ST_FMUL: if (!mul_act_q) x0_q <= mul_acc_q;
			ST_OUT: if (!out_valid || out_ready) begin
				solvable       <= ok_q;
				divisor        <= x_q[NW-1:0];
				first_solution <= x0_q[NW-1:0];
				stride         <= mp_q[NW-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/lcs_checker.sv =====
// Port-level checker for the linear congruence solver, bound to the top level.
module lcs_assertions import lcs_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          solvable,
	input logic [NW-1:0] divisor,
	input logic [NW-1:0] first_solution,
	input logic [NW-1:0] stride
);

	// hold a waiting input beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat dropped before acceptance");

	// hold a stalled result beat, with first solution and stride stable
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_solution) && $stable(stride))
		else $error("result beat changed while stalled");

	// solution lies below the stride
	a_first_lt_stride: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && solvable |-> first_solution < stride)
		else $error("first solution not below stride");

	// drop the solution when not solvable
	a_unsolv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !solvable |-> first_solution == '0)
		else $error("unsolvable result carries a solution");

	// zero gcd only with zero stride
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor == '0 |-> stride == '0 && !solvable)
		else $error("zero divisor with nonzero stride");

endmodule

bind linear_congruence_solver lcs_assertions u_lcs_assertions (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.solvable(solvable),
	.divisor(divisor),
	.first_solution(first_solution),
	.stride(stride)
);

// ===== tb/lcs_checker.sv =====
// Result checker for the linear congruence solver: models each triple and compares results.
module lcs_checker import lcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [NW-1:0]           coefficient,
	input  logic signed [WIDTH-1:0] right_side,
	input  logic [NW-1:0]           modulus,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    solvable,
	input  logic [NW-1:0]           divisor,
	input  logic [NW-1:0]           first_solution,
	input  logic [NW-1:0]           stride,
	output int                      fail_count,
	output int                      pending,
	output int                      solved_count
);

	typedef struct packed {
		logic          ok;
		logic [NW-1:0] g;
		logic [NW-1:0] x0;
		logic [NW-1:0] step;
	} solution_t;

	solution_t solutions_q[$];

	// modular inverse of x mod n by extended Euclid; 0 when n is 1
	function automatic longint unsigned inverse_of(longint unsigned x, longint unsigned n);
		longint unsigned r0, r1, r2, q, t0, t1, t2;
		r0 = n;
		r1 = x % n;
		t0 = 0;
		t1 = (n > 1) ? 1 : 0;
		while (r1 != 0) begin
			q  = r0 / r1;
			r2 = r0 - q * r1;
			t2 = (t0 + n - (q * t1) % n) % n;
			r0 = r1;
			r1 = r2;
			t0 = t1;
			t1 = t2;
		end
		return t0 % n;
	endfunction

	function automatic solution_t solve_triple(logic [NW-1:0] a_in, logic [WIDTH-1:0] b_in,
		logic [NW-1:0] m_in);
		solution_t s;
		longint unsigned a, m, br, mag, g, x, y, t, mp;
		s = '0;
		a = a_in;
		m = m_in;
		if (m == 0)
			return s;
		// bring the right side into 0..m-1
		if (b_in[WIDTH-1]) begin
			mag = longint'(-b_in) & 64'hFFFF_FFFF;
			br = (mag % m == 0) ? 0 : m - mag % m;
		end else begin
			br = b_in % m;
		end
		x = a;
		y = m;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		g = x;
		mp = m / g;
		s.g = g[NW-1:0];
		s.step = mp[NW-1:0];
		if (br % g == 0) begin
			s.ok = 1'b1;
			t = (inverse_of((a / g) % mp, mp) * ((br / g) % mp)) % mp;
			s.x0 = t[NW-1:0];
		end
		return s;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = solutions_q.size();

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		solution_t want;
		if (!arst_n) begin
			fail_count <= 0;
			solved_count <= 0;
			solutions_q.delete();
		end else begin
			if (in_valid && in_ready)
				solutions_q.push_back(solve_triple(coefficient, right_side, modulus));
			if (out_valid && out_ready) begin
				if (solutions_q.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					want = solutions_q.pop_front();
					if (want.ok)
						solved_count <= solved_count + 1;
					if (solvable !== want.ok)
						report_mismatch("solvable", solvable, want.ok);
					if (divisor !== want.g)
						report_mismatch("divisor", divisor, want.g);
					if (first_solution !== want.x0)
						report_mismatch("first_solution", first_solution, want.x0);
					if (stride !== want.step)
						report_mismatch("stride", stride, want.step);
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives congruence triples into the solver and gives the verdict.
module tb import lcs_pkg::*; ();

	localparam int RANDOM_ITEMS = 430;
	localparam int CYCLE_LIMIT  = 20000000;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [NW-1:0]           coefficient;
	logic signed [WIDTH-1:0] right_side;
	logic [NW-1:0]           modulus;
	logic                    out_valid;
	logic                    out_ready;
	logic                    solvable;
	logic [NW-1:0]           divisor;
	logic [NW-1:0]           first_solution;
	logic [NW-1:0]           stride;
	int                      fail_count;
	int                      pending;
	int                      solved_count;
	int                      cycles;
	int                      sent;
	bit                      quiet;

	linear_congruence_solver DUT (.*);

	lcs_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stall the result side in random bursts
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 12);
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// hold a beat until accepted, with an optional gap first
	task automatic send_triple(logic [NW-1:0] a, logic [WIDTH-1:0] b, logic [NW-1:0] m);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		coefficient <= a;
		right_side  <= b;
		modulus     <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [NW-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return NW'($urandom_range(1, 64));
			1: return NW'($urandom_range(1, 5000));
			2: return NW'({1'b1, NW'($urandom)} >> $urandom_range(1, NW));
			default: return NW'($urandom);
		endcase
	endfunction

	initial begin
		logic [NW-1:0] a, m, g;
		cycles = 0;
		sent = 0;
		quiet = 1'b0;
		in_valid = 1'b0;
		coefficient = '0;
		right_side = '0;
		modulus = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes and special cases
		send_triple(31'd1, 32'sd0, 31'd1);
		send_triple('1, '1, '1);
		send_triple('1, 32'h8000_0000, '1);
		send_triple(31'd1, 32'h7FFF_FFFF, '1);
		send_triple(31'd6, 32'sd4, 31'd10);
		send_triple(31'd6, 32'sd5, 31'd10);
		send_triple(31'd6, -32'sd4, 31'd10);
		send_triple(31'd4, -32'sd7, 31'd6);
		send_triple(31'd0, 32'sd0, 31'd9);
		send_triple(31'd0, 32'sd5, 31'd9);
		send_triple(31'd0, -32'sd18, 31'd9);
		send_triple(31'd5, 32'sd3, 31'd0);
		send_triple(31'd0, 32'sd0, 31'd0);
		send_triple(31'd3, 32'h8000_0000, 31'd7);
		send_triple(31'h4000_0000, 32'h4000_0000, 31'h6000_0000);
		send_triple(31'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA);
		send_triple(31'd12, 32'sd18, 31'd30);
		send_triple(31'd7, -32'sd1, 31'h7FFF_FFFE);

		// random triples, half built with a shared factor
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > RANDOM_ITEMS - 60)
				quiet = 1'b1;
			a = pick_value();
			m = pick_value();
			if ($urandom_range(0, 1)) begin
				g = NW'($urandom_range(2, 300));
				a = NW'(a % 100000) * g;
				m = NW'((m % 1000000) + 1) * g;
			end
			if ($urandom_range(0, 40) == 0)
				m = 0;
			if ($urandom_range(0, 40) == 0)
				a = 0;
			send_triple(a, $urandom, m);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("%0d triples sent; %0d solvable, the rest unsolvable or zero modulus.",
			sent, solved_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== linear_congruence_solver.f =====
rtl/lcs_pkg.sv
rtl/linear_congruence_solver.sv
rtl/lcs_checker.sv
tb/lcs_checker.sv
tb/tb.sv
